FILE: rtl/core/image_stream_to_pixel_writes_top_defines.svh
// Assertion macros shared by the image stream to pixel writes RTL.
`ifndef IMAGE_STREAM_TO_PIXEL_WRITES_TOP_DEFINES_SVH
`define IMAGE_STREAM_TO_PIXEL_WRITES_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ISTPW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ISTPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/istpw_pkg.sv
// Types and constants of the image stream to pixel writes block.
`timescale 1ns / 1ps
`default_nettype none

package istpw_pkg;

  localparam int DEFAULT_FRAME_SIZE = 512;
  localparam int QUEUE_DEPTH        = 4;
  localparam int CFG_IDX_W          = 1;

  // header byte positions
  localparam logic [3:0] HB_COLS_LO = 4'd2;
  localparam logic [3:0] HB_COLS_HI = 4'd3;
  localparam logic [3:0] HB_ROWS_LO = 4'd6;
  localparam logic [3:0] HB_ROWS_HI = 4'd7;
  localparam logic [3:0] HB_MODE_LO = 4'd10;
  localparam logic [3:0] HB_LAST    = 4'd11;

  localparam logic [7:0] MODE_NARROW = 8'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ROWS   = 2'd1,
    PH_IGNORE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_HDR_TRUNC = 2'd1,
    KIND_ROW_TRUNC = 2'd2
  } result_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_COLUMN = 1'd0,
    CFG_ORIGIN_ROW    = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [8:0]   frame_row;
    logic [8:0]   frame_column;
    logic [15:0]  pixel_value;
  } out_item_t;

  typedef struct packed {
    logic [8:0] origin_column;
    logic [8:0] origin_row;
  } cfg_t;

  // classified item handed from front to back; indices are image-relative
  typedef struct packed {
    result_kind_e kind;
    logic [8:0]   row_idx;
    logic [8:0]   col_idx;
    logic [15:0]  value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/istpw_front.sv
// Front end: header parsing, clipping and per-byte classification.
`timescale 1ns / 1ps
`default_nettype none
`include "image_stream_to_pixel_writes_top_defines.svh"

module istpw_front import istpw_pkg::*; #(
  parameter int FRAME_SIZE = DEFAULT_FRAME_SIZE
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  input  wire cfg_t      cfg_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  localparam int         CW      = $clog2(FRAME_SIZE + 1);
  localparam logic [16:0] FRAME_W = 17'(FRAME_SIZE);

  phase_e          phase_q, phase_d;
  logic [3:0]      hdr_cnt_q, hdr_cnt_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     cols_q, cols_d;
  logic [15:0]     rows_q, rows_d;
  logic            wide_q, wide_d;
  logic [CW-1:0]   kept_cols_q, kept_cols_d;
  logic [CW-1:0]   kept_rows_q, kept_rows_d;
  logic [CW-1:0]   row_cnt_q, row_cnt_d;
  logic [16:0]     bir_q, bir_d;

  logic            accept;
  logic [7:0]      b;
  logic            wide_new;
  logic [16:0]     origin_col_w, origin_row_w;
  logic [16:0]     room_col, room_row;
  logic [16:0]     kept_col_w, kept_row_w;
  logic [CW-1:0]   kept_cols_new, kept_rows_new;
  logic [16:0]     row_bytes;
  logic [16:0]     bir_inc;
  logic [CW-1:0]   row_inc;
  logic            row_end;
  logic [CW+8:0]   row_ext;
  logic [8:0]      row_idx;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign b          = in_item_i.data_byte;

  assign wide_new = !(held_q == MODE_NARROW && b == 8'd0);

  // clip to the frame: min(count, FRAME_SIZE - origin), floored at zero
  assign origin_col_w  = 17'(cfg_i.origin_column);
  assign origin_row_w  = 17'(cfg_i.origin_row);
  assign room_col      = (origin_col_w < FRAME_W) ? FRAME_W - origin_col_w : '0;
  assign room_row      = (origin_row_w < FRAME_W) ? FRAME_W - origin_row_w : '0;
  assign kept_col_w    = (17'(cols_q) < room_col) ? 17'(cols_q) : room_col;
  assign kept_row_w    = (17'(rows_q) < room_row) ? 17'(rows_q) : room_row;
  assign kept_cols_new = kept_col_w[CW-1:0];
  assign kept_rows_new = kept_row_w[CW-1:0];

  assign row_bytes = wide_q ? {cols_q, 1'b0} : {1'b0, cols_q};
  assign bir_inc   = bir_q + 17'd1;
  assign row_inc   = row_cnt_q + CW'(1);
  assign row_end   = bir_inc >= row_bytes;
  assign row_ext   = {9'd0, row_cnt_q};
  assign row_idx   = row_ext[8:0];

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (in_item_i.end_of_file) begin
        phase_d = PH_HEADER;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (hdr_cnt_q == HB_LAST) begin
              phase_d = (kept_rows_new == '0 || cols_q == 16'd0) ? PH_IGNORE : PH_ROWS;
            end
          end
          PH_ROWS: begin
            if (row_end && row_inc >= kept_rows_q) begin
              phase_d = PH_IGNORE;
            end
          end
          PH_IGNORE: ;
          default: phase_d = PH_HEADER;
        endcase
      end
    end
  end

  // datapath and classification
  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    held_d      = held_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    wide_d      = wide_q;
    kept_cols_d = kept_cols_q;
    kept_rows_d = kept_rows_q;
    row_cnt_d   = row_cnt_q;
    bir_d       = bir_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    if (accept) begin
      if (in_item_i.end_of_file) begin
        push_o       = (phase_q == PH_HEADER) || (phase_q == PH_ROWS);
        cmd_o.kind    = (phase_q == PH_HEADER) ? KIND_HDR_TRUNC : KIND_ROW_TRUNC;
        cmd_o.row_idx = (phase_q == PH_ROWS) ? row_idx : 9'd0;
        hdr_cnt_d   = '0;
        held_d      = '0;
        cols_d      = '0;
        rows_d      = '0;
        wide_d      = 1'b0;
        kept_cols_d = '0;
        kept_rows_d = '0;
        row_cnt_d   = '0;
        bir_d       = '0;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            unique case (hdr_cnt_q)
              HB_COLS_LO: cols_d = {8'd0, b};
              HB_COLS_HI: cols_d = {b, cols_q[7:0]};
              HB_ROWS_LO: rows_d = {8'd0, b};
              HB_ROWS_HI: rows_d = {b, rows_q[7:0]};
              HB_MODE_LO: held_d = b;
              HB_LAST:    wide_d = wide_new;
              default: ;
            endcase
            hdr_cnt_d = hdr_cnt_q + 4'd1;
            if (hdr_cnt_q == HB_LAST) begin
              hdr_cnt_d   = '0;
              held_d      = '0;
              kept_cols_d = kept_cols_new;
              kept_rows_d = kept_rows_new;
              row_cnt_d   = '0;
              bir_d       = '0;
            end
          end
          PH_ROWS: begin
            cmd_o.kind    = KIND_PIXEL;
            cmd_o.row_idx = row_idx;
            if (!wide_q) begin
              cmd_o.col_idx = bir_q[8:0];
              cmd_o.value   = {4'd0, b, 4'd0};
              push_o        = bir_q < 17'(kept_cols_q);
            end else if (!bir_q[0]) begin
              held_d = b;
            end else begin
              cmd_o.col_idx = bir_q[9:1];
              cmd_o.value   = {b, held_q};
              push_o        = bir_q[16:1] < 16'(kept_cols_q);
            end
            bir_d = bir_inc;
            if (row_end) begin
              bir_d     = '0;
              row_cnt_d = row_inc;
            end
          end
          PH_IGNORE: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      held_q      <= '0;
      cols_q      <= '0;
      rows_q      <= '0;
      wide_q      <= 1'b0;
      kept_cols_q <= '0;
      kept_rows_q <= '0;
      row_cnt_q   <= '0;
      bir_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      held_q      <= held_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      wide_q      <= wide_d;
      kept_cols_q <= kept_cols_d;
      kept_rows_q <= kept_rows_d;
      row_cnt_q   <= row_cnt_d;
      bir_q       <= bir_d;
    end
  end

  `ISTPW_ASSERT(a_hdr_cnt_range, clk_i, rst_ni, hdr_cnt_q <= HB_LAST, "header count past end")
  `ISTPW_ASSERT(a_rows_nonempty, clk_i, rst_ni, phase_q != PH_ROWS || (kept_rows_q != '0 && row_cnt_q < kept_rows_q), "row phase with no rows left")
  `ISTPW_ASSERT(a_bir_in_row, clk_i, rst_ni, phase_q != PH_ROWS || bir_q < row_bytes, "byte index beyond row")

endmodule

`default_nettype wire

FILE: rtl/core/istpw_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
`include "image_stream_to_pixel_writes_top_defines.svh"

module istpw_queue import istpw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output q_status_t status_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = cnt_q == CNT_FULL;
  assign status_o.empty = cnt_q == '0;
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `ISTPW_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && status_o.full), "push into full queue")
  `ISTPW_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && status_o.empty), "pop from empty queue")
  `ISTPW_ASSERT_NEXT(a_cnt_grows, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1), "count did not follow push")

endmodule

`default_nettype wire

FILE: rtl/core/istpw_back.sv
// Back end: places classified items in the frame and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module istpw_back import istpw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire q_status_t q_status_i,
  input  wire cmd_t      cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      is_pixel;

  assign pop_o    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign is_pixel = cmd_i.kind == KIND_PIXEL;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (pop_o) begin
      out_valid_d              = 1'b1;
      out_item_d.result_kind   = cmd_i.kind;
      out_item_d.frame_row     = is_pixel ? cfg_i.origin_row + cmd_i.row_idx : cmd_i.row_idx;
      out_item_d.frame_column  = is_pixel ? cfg_i.origin_column + cmd_i.col_idx : 9'd0;
      out_item_d.pixel_value   = is_pixel ? cmd_i.value : 16'd0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: rtl/core/image_stream_to_pixel_writes_top.sv
// Top level of the image stream to pixel writes block.
// Usage:
//   in channel: one file byte per item (in_valid_i / in_stall_o); an item with
//   end_of_file set closes the stream and rearms the parser.
//   out channel: pixel writes and truncation reports (out_valid_o / out_stall_i).
//   cfg channel: origin_column (index 0) and origin_row (index 1), always
//   ready; write only while the block is idle.
// Path: the result of an accepted byte is written into the front/back queue
//   at the accepting edge; the back end then pops it from the queue into the
//   output register.
// Throughput: one byte per cycle while in_stall_o is low. The front only
//   updates counters and does a compare per byte; the four-entry queue and
//   output register let the front keep taking bytes while the receiver
//   stalls, and in_stall_o rises only once the queue is full.
// Reset: parser returns to the header phase, queue and output are emptied,
//   both origins return to zero.

`timescale 1ns / 1ps
`default_nettype none

module image_stream_to_pixel_writes_top import istpw_pkg::*; #(
  parameter int FRAME_SIZE = DEFAULT_FRAME_SIZE
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [8:0]           cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      push;
  logic      pop;
  cmd_t      cmd_in, cmd_out;
  q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ORIGIN_COLUMN: cfg_d.origin_column = cfg_data_i;
        CFG_ORIGIN_ROW:    cfg_d.origin_row    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  istpw_front #(
    .FRAME_SIZE(FRAME_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  istpw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .status_o (q_status)
  );

  istpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the image stream to pixel writes block.
module testbench;
  import istpw_pkg::*;

  localparam int FRAME         = DEFAULT_FRAME_SIZE;
  localparam int PHASES        = 9;
  localparam int RANDOM_ITEMS  = 700;
  localparam int DATA_CAP      = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct packed {
    cfg_reg_e   index;
    logic [8:0] data;
  } reg_write_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_e   cfg_index = CFG_ORIGIN_COLUMN;
  logic [8:0] cfg_data = '0;

  // predictor copy of registers and parser state
  logic [8:0]  origin_col = '0;
  logic [8:0]  origin_row = '0;
  phase_e      parse_phase = PH_HEADER;
  logic [3:0]  hdr_count = '0;
  logic [7:0]  held_byte = '0;
  logic [15:0] file_cols = '0;
  logic [15:0] file_rows = '0;
  logic        wide = 1'b0;
  logic [9:0]  kept_cols = '0;
  logic [9:0]  kept_rows = '0;
  logic [9:0]  row_count = '0;
  logic [16:0] row_pos = '0;

  in_item_t    file_bytes_pending[$];
  out_item_t   pixel_writes_due[$];
  reg_write_t  reg_writes_pending[$];
  out_item_t   predicted_write;
  out_item_t   expected_write;
  reg_write_t  next_reg_write;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned reg_writes_queued = 0;
  int unsigned reg_writes_done = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  image_stream_to_pixel_writes_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [9:0] clip_count(input logic [15:0] count, input logic [8:0] origin);
    logic [9:0] room;
    room = 10'(FRAME) - {1'b0, origin};
    return (count < {6'd0, room}) ? count[9:0] : room;
  endfunction

  function automatic logic [16:0] bytes_per_row();
    return wide ? {file_cols, 1'b0} : {1'b0, file_cols};
  endfunction

  function automatic bit parse_byte(input in_item_t item, output out_item_t res);
    bit         made;
    logic [7:0] b;
    made = 1'b0;
    res  = '0;
    b    = item.data_byte;
    if (item.end_of_file) begin
      if (parse_phase == PH_HEADER) begin
        res.result_kind = KIND_HDR_TRUNC;
        made = 1'b1;
      end else if (parse_phase == PH_ROWS) begin
        res.result_kind = KIND_ROW_TRUNC;
        res.frame_row   = row_count[8:0];
        made = 1'b1;
      end
      parse_phase = PH_HEADER;
      hdr_count   = '0;
      held_byte   = '0;
      file_cols   = '0;
      file_rows   = '0;
      wide        = 1'b0;
      kept_cols   = '0;
      kept_rows   = '0;
      row_count   = '0;
      row_pos     = '0;
    end else if (parse_phase == PH_HEADER) begin
      case (hdr_count)
        HB_COLS_LO: file_cols[7:0] = b;
        HB_COLS_HI: file_cols[15:8] = b;
        HB_ROWS_LO: file_rows[7:0] = b;
        HB_ROWS_HI: file_rows[15:8] = b;
        HB_MODE_LO: held_byte = b;
        HB_LAST:    wide = !(held_byte == MODE_NARROW && b == 8'd0);
        default: ;
      endcase
      if (hdr_count == HB_LAST) begin
        hdr_count   = '0;
        held_byte   = '0;
        kept_cols   = clip_count(file_cols, origin_col);
        kept_rows   = clip_count(file_rows, origin_row);
        row_count   = '0;
        row_pos     = '0;
        parse_phase = (kept_rows == 10'd0 || bytes_per_row() == 17'd0) ? PH_IGNORE : PH_ROWS;
      end else begin
        hdr_count = hdr_count + 1'b1;
      end
    end else if (parse_phase == PH_ROWS) begin
      if (!wide) begin
        if (row_pos < {7'd0, kept_cols}) begin
          res.result_kind  = KIND_PIXEL;
          res.frame_row    = origin_row + row_count[8:0];
          res.frame_column = origin_col + row_pos[8:0];
          res.pixel_value  = {4'h0, b, 4'h0};
          made = 1'b1;
        end
      end else if (!row_pos[0]) begin
        held_byte = b;
      end else if (row_pos[16:1] < {6'd0, kept_cols}) begin
        res.result_kind  = KIND_PIXEL;
        res.frame_row    = origin_row + row_count[8:0];
        res.frame_column = origin_col + row_pos[9:1];
        res.pixel_value  = {b, held_byte};
        made = 1'b1;
      end
      row_pos = row_pos + 1'b1;
      if (row_pos >= bytes_per_row()) begin
        row_pos   = '0;
        row_count = row_count + 1'b1;
        if (row_count >= kept_rows) parse_phase = PH_IGNORE;
      end
    end
    return made;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_item_t item;
    item.data_byte   = b;
    item.end_of_file = 1'b0;
    file_bytes_pending.push_back(item);
    bytes_queued++;
  endtask

  task automatic push_eof();
    in_item_t item;
    item.data_byte   = 8'($urandom);
    item.end_of_file = 1'b1;
    file_bytes_pending.push_back(item);
    bytes_queued++;
  endtask

  task automatic push_header(input logic [15:0] cols, input logic [15:0] rows,
                             input logic [15:0] mode);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    push_byte(cols[7:0]);
    push_byte(cols[15:8]);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    push_byte(rows[7:0]);
    push_byte(rows[15:8]);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    push_byte(mode[7:0]);
    push_byte(mode[15:8]);
  endtask

  task automatic queue_reg_write(input cfg_reg_e index, input logic [8:0] data);
    reg_write_t w;
    w.index = index;
    w.data  = data;
    reg_writes_pending.push_back(w);
    reg_writes_queued++;
  endtask

  function automatic logic [15:0] pick_count(input int unsigned room);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) return 16'($urandom_range(0, 10));
    if (sel < 90) return 16'(room - 1 + $urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_mode();
    logic [15:0] mode;
    case ($urandom_range(3))
      0, 1: mode = 16'd1;
      2:    mode = {8'($urandom_range(1, 255)), 8'd1};
      default: begin
        mode = 16'($urandom);
        if (mode == 16'd1) mode = 16'd0;
      end
    endcase
    return mode;
  endfunction

  function automatic int unsigned data_bytes_needed(input logic [15:0] cols,
                                                    input logic [15:0] rows,
                                                    input logic [15:0] mode);
    int unsigned room;
    int unsigned per_row;
    room    = FRAME - int'(origin_row);
    per_row = (mode == 16'd1) ? int'(cols) : 2 * int'(cols);
    return per_row * ((int'(rows) < room) ? int'(rows) : room);
  endfunction

  task automatic queue_random_image();
    logic [15:0] cols;
    logic [15:0] rows;
    logic [15:0] mode;
    int unsigned needed;
    if ($urandom_range(99) < 8) begin
      // header cut short
      repeat ($urandom_range(0, 11)) push_byte(8'($urandom));
      push_eof();
    end else begin
      cols   = pick_count(FRAME - int'(origin_col));
      rows   = pick_count(FRAME - int'(origin_row));
      mode   = pick_mode();
      push_header(cols, rows, mode);
      needed = data_bytes_needed(cols, rows, mode);
      if (needed == 0 || (needed <= DATA_CAP && $urandom_range(99) < 80)) begin
        repeat (needed + $urandom_range(0, 3)) push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(0, ((needed < DATA_CAP) ? needed : DATA_CAP) - 1))
          push_byte(8'($urandom));
      end
      push_eof();
    end
  endtask

  // input driver and predictor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_byte(in_item, predicted_write)) pixel_writes_due.push_back(predicted_write);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (file_bytes_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_item  <= file_bytes_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register writes
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_index <= CFG_ORIGIN_COLUMN;
      cfg_data  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_COLUMN: origin_col = cfg_data;
          CFG_ORIGIN_ROW:    origin_row = cfg_data;
          default: ;
        endcase
        reg_writes_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes_pending.size() != 0) begin
          next_reg_write = reg_writes_pending.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_reg_write.index;
          cfg_data  <= next_reg_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    error_count++;
  endtask

  // output monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_writes_due.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual kind %0d row %0d col %0d val 0x%0h",
                   $time, out_item.result_kind, out_item.frame_row, out_item.frame_column,
                   out_item.pixel_value);
          error_count++;
        end else begin
          expected_write = pixel_writes_due.pop_front();
          if (out_item.result_kind !== expected_write.result_kind)
            report_mismatch("result_kind", 16'(expected_write.result_kind),
                            16'(out_item.result_kind));
          if (out_item.frame_row !== expected_write.frame_row)
            report_mismatch("frame_row", 16'(expected_write.frame_row), 16'(out_item.frame_row));
          if (out_item.frame_column !== expected_write.frame_column)
            report_mismatch("frame_column", 16'(expected_write.frame_column),
                            16'(out_item.frame_column));
          if (out_item.pixel_value !== expected_write.pixel_value)
            report_mismatch("pixel_value", expected_write.pixel_value, out_item.pixel_value);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [8:0]  col_pick;
    logic [8:0]  row_pick;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [15:0] mode;
    int unsigned needed;
    int unsigned target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      gap_pct   = (p < 3) ? 26 : (p < 6) ? 54 : 0;
      stall_pct = (p < 3) ? 54 : (p < 6) ? 26 : 0;
      case (p)
        0:       {col_pick, row_pick} = {9'd0, 9'd0};
        1:       {col_pick, row_pick} = {9'd511, 9'd511};
        2:       {col_pick, row_pick} = {9'd505, 9'd500};
        3:       {col_pick, row_pick} = {9'd0, 9'd511};
        4:       {col_pick, row_pick} = {9'd511, 9'd0};
        5:       {col_pick, row_pick} = {9'd490, 9'd3};
        default: {col_pick, row_pick} = 18'($urandom);
      endcase
      queue_reg_write(CFG_ORIGIN_COLUMN, col_pick);
      queue_reg_write(CFG_ORIGIN_ROW, row_pick);
      while (reg_writes_done != reg_writes_queued) @(posedge clk);

      if (p == 0) begin
        // eof before any header byte
        push_eof();
        // 3 x 2 image, one byte per pixel, then a stray byte and rearm
        push_header(16'd3, 16'd2, 16'd1);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'h80);
        push_byte(8'h7f);
        push_byte(8'h01);
        push_byte(8'hfe);
        push_byte(8'h5a);
        push_eof();
        // eof partway through the header
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(8'h07);
        push_eof();
      end else begin
        // finish the image left open across the origin change
        repeat ($urandom_range(0, 8)) push_byte(8'($urandom));
        push_eof();
      end

      target = 25 + RANDOM_ITEMS * (p + 1) / PHASES;
      while (bytes_queued < target) queue_random_image();

      // leave an image open in its rows so the next origin lands mid-image
      cols   = 16'($urandom_range(1, 6));
      rows   = 16'($urandom_range(2, 4));
      mode   = pick_mode();
      push_header(cols, rows, mode);
      needed = data_bytes_needed(cols, rows, mode);
      repeat ($urandom_range(0, needed - 1)) push_byte(8'($urandom));

      while (bytes_taken != bytes_queued || pixel_writes_due.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/istpw_pkg.sv
rtl/core/istpw_front.sv
rtl/core/istpw_queue.sv
rtl/core/istpw_back.sv
rtl/core/image_stream_to_pixel_writes_top.sv
sim/testbench.sv
